// ===== rtl/ifhg_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Shared constants, control and status types, and the checksum adder.
// ----------------------------------------------------------------------------
package ifhg_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned MTU_W        = 14;
  localparam int unsigned LEN_W        = 16;

  localparam logic [MTU_W-1:0] MTU_LOW   = 14'd1052;
  localparam logic [MTU_W-1:0] MTU_HIGH  = 14'd9000;
  localparam logic [MTU_W-1:0] MTU_RESET = 14'd1500;

  localparam logic [15:0] CSUM_INIT = 16'hffff;
  localparam logic [7:0]  VER_IHL   = 8'h45;

  localparam int unsigned BASE_WORDS = 7;
  localparam int unsigned WSEL_W     = 3;

  localparam logic [WSEL_W-1:0] W_TOS     = 3'd0;
  localparam logic [WSEL_W-1:0] W_IDENT   = 3'd1;
  localparam logic [WSEL_W-1:0] W_TTL     = 3'd2;
  localparam logic [WSEL_W-1:0] W_SRC_HI  = 3'd3;
  localparam logic [WSEL_W-1:0] W_SRC_LO  = 3'd4;
  localparam logic [WSEL_W-1:0] W_DST_HI  = 3'd5;
  localparam logic [WSEL_W-1:0] W_DST_LO  = 3'd6;

  typedef struct packed {
    logic              load;
    logic              base_add;
    logic [WSEL_W-1:0] word_sel;
    logic              frag;
    logic              add_len;
    logic              add_foff;
  } ifhg_cmd_t;

  typedef struct packed {
    logic last;
  } ifhg_sts_t;

  function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] sum;
    sum = {1'b0, acc} + {1'b0, word};
    if (sum[16]) begin
      csum_add = sum[15:0] + 16'd1;
    end else begin
      csum_add = sum[15:0];
    end
  endfunction

endpackage

// ===== rtl/ifhg_dp.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator datapath
// Holds the link size register, the header fields, fragment counters and the
// ones complement checksum base and fragment accumulator registers.
// ----------------------------------------------------------------------------
module ifhg_dp import ifhg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [13:0]      cfg_wr_data,
  input  ifhg_cmd_t        cmd,
  output ifhg_sts_t        sts,
  input  logic [7:0]       in_type_of_service,
  input  logic [15:0]      in_ident,
  input  logic [7:0]       in_time_to_live,
  input  logic [7:0]       in_protocol_number,
  input  logic [31:0]      in_source_addr,
  input  logic [31:0]      in_dest_addr,
  input  logic [15:0]      in_total_length,
  output logic [13:0]      out_fragment_length,
  output logic [13:0]      out_flags_offset,
  output logic [15:0]      out_header_checksum,
  output logic [15:0]      out_data_offset,
  output logic             out_last_fragment
);

  logic [MTU_W-1:0] mtu_r;
  logic [7:0]       tos_r;
  logic [15:0]      ident_r;
  logic [7:0]       ttl_r;
  logic [7:0]       proto_r;
  logic [31:0]      src_r;
  logic [31:0]      dst_r;
  logic [MTU_W-1:0] maxdata_r;
  logic [LEN_W-1:0] bytes_r;
  logic [LEN_W-1:0] offset_r;
  logic [15:0]      base_r;
  logic [15:0]      acc_r;
  logic [13:0]      flen_r;
  logic [13:0]      foff_r;
  logic [15:0]      doff_r;
  logic             last_r;

  logic [MTU_W-1:0] mtu_cl;
  logic [MTU_W-1:0] md_raw;
  logic [LEN_W-1:0] bytes_init;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rem;
  logic [15:0]      base_word;

  always_comb begin
    if (mtu_r < MTU_LOW) begin
      mtu_cl = MTU_LOW;
    end else if (mtu_r > MTU_HIGH) begin
      mtu_cl = MTU_HIGH;
    end else begin
      mtu_cl = mtu_r;
    end
    md_raw = mtu_cl - MTU_W'(HEADER_BYTES + 1);
    if (in_total_length >= LEN_W'(HEADER_BYTES)) begin
      bytes_init = in_total_length - LEN_W'(HEADER_BYTES);
    end else begin
      bytes_init = '0;
    end
    if (bytes_r < {2'b00, maxdata_r}) begin
      plen = bytes_r;
    end else begin
      plen = {2'b00, maxdata_r};
    end
    rem = bytes_r - plen;
    case (cmd.word_sel)
      W_TOS:    base_word = {VER_IHL, tos_r};
      W_IDENT:  base_word = ident_r;
      W_TTL:    base_word = {ttl_r, proto_r};
      W_SRC_HI: base_word = src_r[31:16];
      W_SRC_LO: base_word = src_r[15:0];
      W_DST_HI: base_word = dst_r[31:16];
      W_DST_LO: base_word = dst_r[15:0];
      default:  base_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= MTU_RESET;
    end else if (cfg_wr_en) begin
      mtu_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tos_r     <= in_type_of_service;
      ident_r   <= in_ident;
      ttl_r     <= in_time_to_live;
      proto_r   <= in_protocol_number;
      src_r     <= in_source_addr;
      dst_r     <= in_dest_addr;
      maxdata_r <= {md_raw[MTU_W-1:3], 3'b000};
      bytes_r   <= bytes_init;
      offset_r  <= '0;
      base_r    <= CSUM_INIT;
    end
    if (cmd.base_add) begin
      base_r <= csum_add(base_r, base_word);
    end
    if (cmd.frag) begin
      flen_r   <= 14'(HEADER_BYTES) + plen[13:0];
      foff_r   <= {(rem != '0), offset_r[15:3]};
      doff_r   <= offset_r;
      offset_r <= offset_r + plen;
      bytes_r  <= rem;
      last_r   <= (rem == '0);
      acc_r    <= base_r;
    end
    if (cmd.add_len) begin
      acc_r <= csum_add(acc_r, {2'b00, flen_r});
    end
    if (cmd.add_foff) begin
      acc_r <= csum_add(acc_r, {2'b00, foff_r});
    end
  end

  assign sts.last            = last_r;
  assign out_fragment_length = flen_r;
  assign out_flags_offset    = foff_r;
  assign out_header_checksum = ~acc_r;
  assign out_data_offset     = doff_r;
  assign out_last_fragment   = last_r;

endmodule

// ===== rtl/ifhg_ctrl.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator controller
// Sequences the header sum, then each fragment's sizing, checksum and output.
// ----------------------------------------------------------------------------
module ifhg_ctrl import ifhg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ifhg_sts_t sts,
  output ifhg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_FRAG = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_FOFF = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [WSEL_W-1:0] cnt_r;
  logic [WSEL_W-1:0] cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.word_sel = cnt_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd.base_add = 1'b1;
        if (cnt_r == WSEL_W'(BASE_WORDS - 1)) begin
          state_nxt = S_FRAG;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FRAG: begin
        cmd.frag  = 1'b1;
        state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.add_len = 1'b1;
        state_nxt   = S_FOFF;
      end
      S_FOFF: begin
        cmd.add_foff = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = sts.last ? S_IDLE : S_FRAG;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_base_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BASE |-> cnt_r < WSEL_W'(BASE_WORDS))
    else $error("Header word counter out of range.");

  a_load_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_BASE && cnt_r == '0)
    else $error("Accepted item did not start the header sum.");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && sts.last |=> state_r == S_IDLE)
    else $error("Final fragment did not return to idle.");

  a_next_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !sts.last |=> state_r == S_FRAG)
    else $error("Fragment taken without moving to the next one.");

endmodule

// ===== rtl/ipv4_fragment_header_generator_top.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Turns one option-free IPv4 header and its total length into one item per
// fragment, each with its length, flags/offset word, data offset and checksum.
// ----------------------------------------------------------------------------
// The input channel takes one header item when in_valid is high and in_stall
// is low; in_stall stays high from acceptance until the final fragment item
// has been taken. The output channel presents one fragment item while
// out_valid is high; it is taken when out_stall is low.
// After acceptance, the seven fixed header words are summed into a base in
// S_BASE; each fragment then passes through S_FRAG to size it and S_LEN and
// S_FOFF to add its length and flags/offset words, one add per cycle into
// the fragment checksum accumulator, before S_EMIT presents it. A packet has
// N fragments, with N at most 64.
// When the receiver stalls, the fragment item and all state hold until it
// is taken. The user writes the link size register through cfg_wr_en and
// cfg_wr_data only while idle, which the block does not enforce. Reset
// idles the controller and sets the link size to 1500; nothing is in flight.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator_top import ifhg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_type_of_service,
  input  logic [15:0] in_ident,
  input  logic [7:0]  in_time_to_live,
  input  logic [7:0]  in_protocol_number,
  input  logic [31:0] in_source_addr,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_fragment_length,
  output logic [13:0] out_flags_offset,
  output logic [15:0] out_header_checksum,
  output logic [15:0] out_data_offset,
  output logic        out_last_fragment
);

  ifhg_cmd_t cmd;
  ifhg_sts_t sts;

  ifhg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ifhg_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_type_of_service  (in_type_of_service),
    .in_ident            (in_ident),
    .in_time_to_live     (in_time_to_live),
    .in_protocol_number  (in_protocol_number),
    .in_source_addr      (in_source_addr),
    .in_dest_addr        (in_dest_addr),
    .in_total_length     (in_total_length),
    .out_fragment_length (out_fragment_length),
    .out_flags_offset    (out_flags_offset),
    .out_header_checksum (out_header_checksum),
    .out_data_offset     (out_data_offset),
    .out_last_fragment   (out_last_fragment)
  );

endmodule
